[src/rpi_pkg.sv]
`timescale 1ns / 1ps

package rpi_pkg;

	// Field widths of the interface
	localparam int VAL_W = 32;
	localparam int IDX_W = 3;
	// Width of the divisor, |normal . dir| < 2^64
	localparam int DIV_W = 64;

	// Register indexes of the configuration port
	localparam logic [IDX_W-1:0] CFG_NORMAL_X = 3'd0;
	localparam logic [IDX_W-1:0] CFG_NORMAL_Y = 3'd1;
	localparam logic [IDX_W-1:0] CFG_NORMAL_Z = 3'd2;
	localparam logic [IDX_W-1:0] CFG_ANCHOR_X = 3'd3;
	localparam logic [IDX_W-1:0] CFG_ANCHOR_Y = 3'd4;
	localparam logic [IDX_W-1:0] CFG_ANCHOR_Z = 3'd5;

	// Clamp values of the distance
	localparam logic [VAL_W-1:0] DIST_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] DIST_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [VAL_W-1:0] origin_x;
		logic signed [VAL_W-1:0] origin_y;
		logic signed [VAL_W-1:0] origin_z;
		logic signed [VAL_W-1:0] dir_x;
		logic signed [VAL_W-1:0] dir_y;
		logic signed [VAL_W-1:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] distance;
		logic                    hit_valid;
		logic                    facing_away;
		logic                    saturated;
	} res_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] normal_x;
		logic signed [VAL_W-1:0] normal_y;
		logic signed [VAL_W-1:0] normal_z;
		logic signed [VAL_W-1:0] anchor_x;
		logic signed [VAL_W-1:0] anchor_y;
		logic signed [VAL_W-1:0] anchor_z;
	} plane_t;

	// Per-item control bits riding along the divider chain
	typedef struct packed {
		logic vld;
		logic parallel;
		logic neg;
		logic ovf;
		logic facing;
	} div_ctl_t;

endpackage

[src/rpi_front.sv]
`timescale 1ns / 1ps

module rpi_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               vld,
	input  rpi_pkg::ray_t                      ray,
	input  rpi_pkg::plane_t                    plane,
	output rpi_pkg::div_ctl_t                  ctl,
	output logic [rpi_pkg::DIV_W-1:0]          rem,
	output logic [rpi_pkg::VAL_W-1:0]          word,
	output logic [rpi_pkg::DIV_W-1:0]          div
);

	// scaled numerator width: |num| < 2^65, times 2^FRAC_BITS
	localparam int NW   = 65 + FRAC_BITS;
	localparam int HI_W = NW - rpi_pkg::VAL_W;

	logic signed [31:0] nrm [3];
	logic signed [31:0] org [3];
	logic signed [31:0] anc [3];
	logic signed [31:0] dir [3];

	assign nrm[0] = plane.normal_x;
	assign nrm[1] = plane.normal_y;
	assign nrm[2] = plane.normal_z;
	assign anc[0] = plane.anchor_x;
	assign anc[1] = plane.anchor_y;
	assign anc[2] = plane.anchor_z;
	assign org[0] = ray.origin_x;
	assign org[1] = ray.origin_y;
	assign org[2] = ray.origin_z;
	assign dir[0] = ray.dir_x;
	assign dir[1] = ray.dir_y;
	assign dir[2] = ray.dir_z;

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic signed [31:0] dir_s1  [3];
	logic signed [32:0] diff_s1 [3];
	logic signed [63:0] pp_s2   [3];
	logic signed [64:0] pn_s2   [3];
	logic signed [65:0] proj_s3;
	logic signed [66:0] num_s3;
	logic [63:0]        pmag_s4;
	logic [64:0]        nmag_s4;
	logic               pneg_s4, neg_s4, parallel_s4;

	logic signed [65:0] proj_abs;
	logic signed [66:0] num_abs;
	logic [NW-1:0]      scaled;
	logic [HI_W-1:0]    hi;
	logic [63:0]        hi_ext;
	logic               ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			ctl    <= '0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			ctl.vld      <= vld_s4;
			ctl.parallel <= parallel_s4;
			ctl.neg      <= neg_s4;
			ctl.ovf      <= ovf;
			ctl.facing   <= !pneg_s4;
		end
	end

	// s1: anchor - origin, 33 bits
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dir_s1[i]  <= dir[i];
				diff_s1[i] <= $signed({anc[i][31], anc[i]}) - $signed({org[i][31], org[i]});
			end
		end
	end

	// s2: six lane products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pp_s2[i] <= dir_s1[i] * nrm[i];
				pn_s2[i] <= diff_s1[i] * nrm[i];
			end
		end
	end

	// s3: dot products, exact
	always_ff @(posedge clk) begin
		if (en) begin
			proj_s3 <= 66'(pp_s2[0]) + 66'(pp_s2[1]) + 66'(pp_s2[2]);
			num_s3  <= 67'(pn_s2[0]) + 67'(pn_s2[1]) + 67'(pn_s2[2]);
		end
	end

	// s4: signs and magnitudes
	assign proj_abs = proj_s3[65] ? -proj_s3 : proj_s3;
	assign num_abs  = num_s3[66] ? -num_s3 : num_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pmag_s4     <= proj_abs[63:0];
			nmag_s4     <= num_abs[64:0];
			pneg_s4     <= proj_s3[65];
			neg_s4      <= proj_s3[65] ^ num_s3[66];
			parallel_s4 <= (proj_s3 == '0);
		end
	end

	// s5: quotient >= 2^32 check, then the low 32 bits go down the chain
	assign scaled = {nmag_s4, {FRAC_BITS{1'b0}}};
	assign hi     = scaled[NW-1:rpi_pkg::VAL_W];
	assign hi_ext = {{(64-HI_W){1'b0}}, hi};
	assign ovf    = (hi_ext >= pmag_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			rem  <= ovf ? '0 : hi_ext;
			word <= scaled[rpi_pkg::VAL_W-1:0];
			div  <= pmag_s4;
		end
	end

endmodule

[src/rpi_div_cell.sv]
`timescale 1ns / 1ps

// One restoring step: bring in the next numerator bit, try the subtract.
module rpi_div_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  rpi_pkg::div_ctl_t                  up_ctl,
	input  logic [rpi_pkg::DIV_W-1:0]          up_rem,
	input  logic [rpi_pkg::VAL_W-1:0]          up_word,
	input  logic [rpi_pkg::DIV_W-1:0]          up_div,
	output rpi_pkg::div_ctl_t                  dn_ctl,
	output logic [rpi_pkg::DIV_W-1:0]          dn_rem,
	output logic [rpi_pkg::VAL_W-1:0]          dn_word,
	output logic [rpi_pkg::DIV_W-1:0]          dn_div
);

	logic [rpi_pkg::DIV_W:0]   sh;
	logic [rpi_pkg::DIV_W+1:0] trial;
	logic                      ge;

	// word: numerator bits leave at the top, quotient bits enter at the bottom
	assign sh    = {up_rem, up_word[rpi_pkg::VAL_W-1]};
	assign trial = {1'b0, sh} - {2'b00, up_div};
	assign ge    = !trial[rpi_pkg::DIV_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_ctl <= '0;
		end else if (en) begin
			dn_ctl <= up_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn_rem  <= ge ? trial[rpi_pkg::DIV_W-1:0] : sh[rpi_pkg::DIV_W-1:0];
			dn_word <= {up_word[rpi_pkg::VAL_W-2:0], ge};
			dn_div  <= up_div;
		end
	end

endmodule

[src/rpi_out_buf.sv]
`timescale 1ns / 1ps

// Two-entry result buffer; room is a registered view of the fill level.
module rpi_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rpi_pkg::res_t push_item,
	input  logic          pop,
	output rpi_pkg::res_t head,
	output logic          nonempty,
	output logic          room
);

	rpi_pkg::res_t ent_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_item;
		end
	end

	assign head     = ent_q[rd_q];
	assign nonempty = (cnt_q != 2'd0);
	assign room     = (cnt_q != 2'd2);

endmodule

[src/ray_plane_intersection_top.sv]
`timescale 1ns / 1ps

// Ray against one plane, signed fixed point with FRAC_BITS fraction bits.
// The plane normal and a point on it sit in six config registers (index 0..2
// normal x/y/z, 3..5 anchor x/y/z; indexes 6 and 7 are dropped); the user
// must write them only while the block is idle, which the block does not
// enforce. Each item on the ray channel is an origin and a direction; each
// gives exactly one result item: distance = ((anchor - origin) . normal) /
// (normal . dir), truncated toward zero and clamped to 32 bits with the
// saturated flag set. A parallel ray (zero projection) gives distance -1.0
// with hit_valid low. facing_away is set for a positive projection. Each
// ray passes through operand prep (subtract, lane products, dot sums,
// magnitudes, range check) and a chain of 32 divider cells that each settle
// one quotient bit with a 64-bit subtract. Throughput is one ray per clock;
// the whole pipeline holds while its two-entry output buffer is full, and
// ray_stall is taken straight from that buffer's fill register.
module ray_plane_intersection_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// ray channel
	input  logic                             ray_valid,
	output logic                             ray_stall,
	input  rpi_pkg::ray_t                    ray,
	// result channel
	output logic                             res_valid,
	input  logic                             res_stall,
	output rpi_pkg::res_t                    res,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rpi_pkg::IDX_W-1:0]        cfg_index,
	input  logic [rpi_pkg::VAL_W-1:0]        cfg_data
);

	localparam int NCELL = rpi_pkg::VAL_W;
	// 1.0 and -1.0 in this fixed-point format
	localparam logic [31:0] ONE_FX   = 32'(64'd1 << FRAC_BITS);
	localparam logic [31:0] PAR_DIST = 32'(64'd0 - (64'd1 << FRAC_BITS));

	rpi_pkg::plane_t plane_q;

	// Config registers; the port never pushes back.
	assign cfg_ready = 1'b1;

	// Reset plane: normal +y through the origin.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '{normal_x: '0, normal_y: ONE_FX, normal_z: '0,
				anchor_x: '0, anchor_y: '0, anchor_z: '0};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rpi_pkg::CFG_NORMAL_X: plane_q.normal_x <= cfg_data;
				rpi_pkg::CFG_NORMAL_Y: plane_q.normal_y <= cfg_data;
				rpi_pkg::CFG_NORMAL_Z: plane_q.normal_z <= cfg_data;
				rpi_pkg::CFG_ANCHOR_X: plane_q.anchor_x <= cfg_data;
				rpi_pkg::CFG_ANCHOR_Y: plane_q.anchor_y <= cfg_data;
				rpi_pkg::CFG_ANCHOR_Z: plane_q.anchor_z <= cfg_data;
				default: ;
			endcase
		end
	end

	// Global advance: every stage moves when the output buffer has room.
	logic en;
	logic room;

	assign en        = room;
	assign ray_stall = !room;

	// Chain taps: index 0 is the prep output, NCELL the last cell.
	rpi_pkg::div_ctl_t              ctl_c  [NCELL+1];
	logic [rpi_pkg::DIV_W-1:0]      rem_c  [NCELL+1];
	logic [rpi_pkg::VAL_W-1:0]      word_c [NCELL+1];
	logic [rpi_pkg::DIV_W-1:0]      div_c  [NCELL+1];

	rpi_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.vld   (ray_valid),
		.ray   (ray),
		.plane (plane_q),
		.ctl   (ctl_c[0]),
		.rem   (rem_c[0]),
		.word  (word_c[0]),
		.div   (div_c[0])
	);

	// One quotient bit per cell, MSB first.
	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		rpi_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.up_ctl (ctl_c[g]),
			.up_rem (rem_c[g]),
			.up_word(word_c[g]),
			.up_div (div_c[g]),
			.dn_ctl (ctl_c[g+1]),
			.dn_rem (rem_c[g+1]),
			.dn_word(word_c[g+1]),
			.dn_div (div_c[g+1])
		);
	end

	// Sign, clamp and the parallel case.
	rpi_pkg::div_ctl_t fin_ctl;
	logic [31:0]       q;
	logic              over;
	rpi_pkg::res_t     fin;

	assign fin_ctl = ctl_c[NCELL];
	assign q       = word_c[NCELL];

	always_comb begin
		fin  = '0;
		over = 1'b0;
		priority if (fin_ctl.parallel) begin
			fin.distance = PAR_DIST;
		end else if (!fin_ctl.neg) begin
			over            = fin_ctl.ovf || q[31];
			fin.distance    = over ? rpi_pkg::DIST_MAX : q;
			fin.hit_valid   = 1'b1;
			fin.facing_away = fin_ctl.facing;
			fin.saturated   = over;
		end else begin
			// magnitude up to 2^31 still fits as a negative value
			over            = fin_ctl.ovf || (q > rpi_pkg::DIST_MIN);
			fin.distance    = over ? rpi_pkg::DIST_MIN : (32'd0 - q);
			fin.hit_valid   = 1'b1;
			fin.facing_away = fin_ctl.facing;
			fin.saturated   = over;
		end
	end

	rpi_out_buf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (en && fin_ctl.vld),
		.push_item(fin),
		.pop      (res_valid && !res_stall),
		.head     (res),
		.nonempty (res_valid),
		.room     (room)
	);

endmodule

[src/rpi_checker.sv]
`timescale 1ns / 1ps

module rpi_checker #(
	parameter int FRAC_BITS = 16
) (
	input logic          clk,
	input logic          arst_n,
	input logic          res_valid,
	input logic          res_stall,
	input rpi_pkg::res_t res
);

	localparam logic [31:0] PAR_DIST = 32'(64'd0 - (64'd1 << FRAC_BITS));

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result item dropped while stalled");

	a_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res))
		else $error("stalled result item changed");

	a_parallel: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.hit_valid |->
		res.distance == PAR_DIST && !res.facing_away && !res.saturated)
		else $error("parallel ray result malformed");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.saturated |->
		res.distance == 32'h7FFF_FFFF || res.distance == 32'h8000_0000)
		else $error("saturated distance not at a clamp value");

endmodule

bind ray_plane_intersection_top rpi_checker #(
	.FRAC_BITS(FRAC_BITS)
) u_rpi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res      (res)
);

[bench/plane_hit_checker.sv]
`timescale 1ns / 1ps

// Watches the ray, result and config channels. Keeps its own copy of the plane
// and a queue of predicted hits, and compares every result against the oldest one.
module plane_hit_checker
	import rpi_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ray_valid,
	input  logic              ray_stall,
	input  ray_t              ray,
	input  logic              res_valid,
	input  logic              res_stall,
	input  res_t              res,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [VAL_W-1:0]  cfg_data,
	output int unsigned       errors,
	output int unsigned       outstanding
);

	plane_t plane;
	res_t   hits_due[$];

	// Exact dot products at 128 bits, then a truncating divide and a clamp.
	function automatic res_t plane_hit(input plane_t p, input ray_t r);
		logic signed [127:0] nx, ny, nz, dx, dy, dz;
		logic signed [127:0] rx, ry, rz, proj, num;
		logic [127:0]        pmag, nmag, quo;
		logic                pneg, nneg;
		res_t                o;
		nx = $signed(p.normal_x);
		ny = $signed(p.normal_y);
		nz = $signed(p.normal_z);
		dx = $signed(r.dir_x);
		dy = $signed(r.dir_y);
		dz = $signed(r.dir_z);
		rx = $signed(p.anchor_x);
		ry = $signed(p.anchor_y);
		rz = $signed(p.anchor_z);
		rx = rx - $signed(r.origin_x);
		ry = ry - $signed(r.origin_y);
		rz = rz - $signed(r.origin_z);
		proj = nx * dx + ny * dy + nz * dz;
		num  = rx * nx + ry * ny + rz * nz;
		o = '0;
		if (proj == 0) begin
			// parallel: -1.0, all flags low
			o.distance = -(32'sd1 <<< FRAC_BITS);
			return o;
		end
		pneg = proj[127];
		nneg = num[127];
		pmag = pneg ? -proj : proj;
		nmag = nneg ? -num : num;
		quo  = (nmag << FRAC_BITS) / pmag;
		o.hit_valid   = 1'b1;
		o.facing_away = !pneg;
		if (pneg == nneg || quo == 0) begin
			if (quo > 128'h7FFF_FFFF) begin
				o.distance  = DIST_MAX;
				o.saturated = 1'b1;
			end else
				o.distance = quo[31:0];
		end else begin
			if (quo > 128'h8000_0000) begin
				o.distance  = DIST_MIN;
				o.saturated = 1'b1;
			end else
				o.distance = -quo[31:0];
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			plane = '0;
			plane.normal_y = 32'sd1 <<< FRAC_BITS;
			hits_due.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (hits_due.size() == 0) begin
					$error("unexpected result item: distance %0d", res.distance);
					errors++;
				end else begin
					want = hits_due.pop_front();
					if (res.distance !== want.distance) begin
						$error("distance: expected %0d, got %0d", want.distance, res.distance);
						errors++;
					end
					if (res.hit_valid !== want.hit_valid) begin
						$error("hit_valid: expected %0b, got %0b", want.hit_valid, res.hit_valid);
						errors++;
					end
					if (res.facing_away !== want.facing_away) begin
						$error("facing_away: expected %0b, got %0b",
							want.facing_away, res.facing_away);
						errors++;
					end
					if (res.saturated !== want.saturated) begin
						$error("saturated: expected %0b, got %0b", want.saturated, res.saturated);
						errors++;
					end
				end
			end
			// a ray sees the plane as it was before any write on the same edge
			if (ray_valid && !ray_stall)
				hits_due.push_back(plane_hit(plane, ray));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_NORMAL_X: plane.normal_x = cfg_data;
					CFG_NORMAL_Y: plane.normal_y = cfg_data;
					CFG_NORMAL_Z: plane.normal_z = cfg_data;
					CFG_ANCHOR_X: plane.anchor_x = cfg_data;
					CFG_ANCHOR_Y: plane.anchor_y = cfg_data;
					CFG_ANCHOR_Z: plane.anchor_z = cfg_data;
					default: ;
				endcase
			end
			outstanding = hits_due.size();
		end
	end

endmodule

[bench/ray_plane_intersection_top_tb.sv]
`timescale 1ns / 1ps

// Top of the bench: clock, reset, ray and config stimulus, result stall, verdict.
// Result checks live in plane_hit_checker; rpi_checker is bound into the block.
module ray_plane_intersection_top_tb;
	import rpi_pkg::*;

	localparam int FRAC = 16;
	// Q16.16 constants used by the stimulus
	localparam logic [VAL_W-1:0] ONE  = 32'h0001_0000;
	localparam logic [VAL_W-1:0] MAXV = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] MINV = 32'h8000_0000;
	localparam logic [VAL_W-1:0] ALL1 = 32'hFFFF_FFFF;
	// config indexes past the last register; the block drops these writes
	localparam logic [IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] CFG_SPARE_B = 3'd7;

	localparam int CFG_ROUNDS = 14;
	localparam int RAYS_PER_ROUND = 100;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             ray_valid = 1'b0;
	logic             ray_stall;
	ray_t             ray       = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	res_t             res;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [VAL_W-1:0] cfg_data  = '0;

	int unsigned errors;
	int unsigned outstanding;

	// idle odds in percent, per side
	int unsigned src_idle  = 29;
	int unsigned sink_idle = 52;

	// plane as last loaded; perpendicular rays are built from it
	plane_t plane_set;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ray_plane_intersection_top #(
		.FRAC_BITS (FRAC)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.ray_valid (ray_valid),
		.ray_stall (ray_stall),
		.ray       (ray),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	plane_hit_checker #(
		.FRAC_BITS (FRAC)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.ray_valid   (ray_valid),
		.ray_stall   (ray_stall),
		.ray         (ray),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// Result side: a fresh coin every cycle, so stalls land on every pipeline
	// phase; with sink_idle at zero the block sees a sink that never pushes back.
	always @(negedge clk)
		res_stall <= ($urandom_range(99) < sink_idle);

	// Watchdog. Its limit lies well past the worst case, with long sender gaps
	// and heavy stalls.
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic ray_t mk_ray(input logic [VAL_W-1:0] ox, oy, oz, dx, dy, dz);
		ray_t r;
		r.origin_x = ox;
		r.origin_y = oy;
		r.origin_z = oz;
		r.dir_x    = dx;
		r.dir_y    = dy;
		r.dir_z    = dz;
		return r;
	endfunction

	// within +-4.0
	function automatic logic [VAL_W-1:0] small_val();
		return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
	endfunction

	// Mix of ray shapes: full-range noise, small well-scaled rays (real hits),
	// rays perpendicular to the normal (parallel case) and near-zero directions
	// (quotient blows up and clamps).
	function automatic ray_t random_ray(input plane_t p);
		ray_t        r;
		int unsigned pick;
		pick = $urandom_range(99);
		r = mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		if (pick < 40)
			return r;
		if (pick < 65)
			return mk_ray(small_val(), small_val(), small_val(),
				small_val(), small_val(), small_val());
		if (pick < 80) begin
			if (pick[0])
				r = mk_ray(small_val(), small_val(), small_val(), '0, '0, '0);
			case ($urandom_range(2))
				0: begin
					r.dir_x = p.normal_y;
					r.dir_y = -p.normal_x;
					r.dir_z = '0;
				end
				1: begin
					r.dir_x = '0;
					r.dir_y = p.normal_z;
					r.dir_z = -p.normal_y;
				end
				default: begin
					r.dir_x = p.normal_z;
					r.dir_y = '0;
					r.dir_z = -p.normal_x;
				end
			endcase
			return r;
		end
		r.dir_x = $urandom_range(0, 6) - 3;
		r.dir_y = $urandom_range(0, 6) - 3;
		r.dir_z = $urandom_range(0, 6) - 3;
		return r;
	endfunction

	// Plane per round: the two extreme corners first, then a zero normal
	// (every ray parallel), an axis normal, then random full and small planes.
	function automatic plane_t random_plane(input int rnd);
		plane_t p;
		case (rnd)
			0: p = '{normal_x: MAXV, normal_y: MINV, normal_z: MAXV,
				anchor_x: MINV, anchor_y: MAXV, anchor_z: MINV};
			1: p = '{normal_x: MINV, normal_y: MINV, normal_z: MINV,
				anchor_x: MAXV, anchor_y: MAXV, anchor_z: MAXV};
			2: begin
				p = '0;
				p.anchor_x = $urandom;
				p.anchor_y = $urandom;
				p.anchor_z = $urandom;
			end
			3: begin
				p = '0;
				p.anchor_x = small_val();
				p.anchor_y = small_val();
				p.anchor_z = small_val();
				case ($urandom_range(2))
					0: p.normal_x = $urandom_range(1) ? ONE : -ONE;
					1: p.normal_y = $urandom_range(1) ? ONE : -ONE;
					default: p.normal_z = $urandom_range(1) ? ONE : -ONE;
				endcase
			end
			default: begin
				if (rnd % 2)
					p = '{normal_x: $urandom, normal_y: $urandom, normal_z: $urandom,
						anchor_x: $urandom, anchor_y: $urandom, anchor_z: $urandom};
				else
					p = '{normal_x: small_val(), normal_y: small_val(),
						normal_z: small_val(), anchor_x: small_val(),
						anchor_y: small_val(), anchor_z: small_val()};
			end
		endcase
		return p;
	endfunction

	// One config write; cfg_valid stays up so writes can go back to back.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// All six registers, with a write to a dead index in the middle that must
	// not land on any of them.
	task automatic load_plane(input plane_t p);
		write_reg(CFG_NORMAL_X, p.normal_x);
		write_reg(CFG_NORMAL_Y, p.normal_y);
		write_reg(CFG_NORMAL_Z, p.normal_z);
		write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
		write_reg(CFG_ANCHOR_X, p.anchor_x);
		write_reg(CFG_ANCHOR_Y, p.anchor_y);
		write_reg(CFG_ANCHOR_Z, p.anchor_z);
		@(negedge clk);
		cfg_valid <= 1'b0;
		plane_set = p;
	endtask

	// Presents one ray and returns on the edge that takes it. valid is only
	// dropped when a gap is drawn, so back-to-back items keep it high.
	task automatic send_ray(input ray_t r);
		int unsigned gap;
		gap = 0;
		while (gap < 10 && $urandom_range(99) < src_idle)
			gap++;
		@(negedge clk);
		if (gap != 0) begin
			ray_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		ray_valid <= 1'b1;
		ray       <= r;
		do @(posedge clk); while (ray_stall);
	endtask

	task automatic ray_quiet();
		@(negedge clk);
		ray_valid <= 1'b0;
	endtask

	// one result per ray, so nothing outstanding means the pipe is empty
	task automatic drain();
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin
		int rnd;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rays against the reset plane: y = 0, normal +y. Here
		// distance = -origin_y / dir_y, so y alone steers each case.
		send_ray(mk_ray('0, ONE, '0, '0, -ONE, '0));          // hit at 1.0
		send_ray(mk_ray('0, ONE, '0, '0, ONE, '0));           // behind origin, facing
		send_ray(mk_ray(ONE, ONE, ONE, ONE, '0, -ONE));       // parallel
		send_ray(mk_ray('0, '0, '0, '0, '0, '0));             // zero dir: parallel
		send_ray(mk_ray('0, '0, '0, '0, -ONE, '0));           // origin on plane
		send_ray(mk_ray('0, '0, '0, '0, ONE, '0));            // on plane, facing
		send_ray(mk_ray('0, MAXV, '0, '0, 32'd1, '0));        // clamps negative
		send_ray(mk_ray('0, MINV, '0, '0, 32'd1, '0));        // clamps positive
		send_ray(mk_ray('0, MINV, '0, '0, ONE, '0));          // 2^31: just over max
		send_ray(mk_ray('0, MINV, '0, '0, -ONE, '0));         // exactly min, no clamp
		send_ray(mk_ray('0, 32'h8000_0001, '0, '0, ONE, '0)); // exactly max
		send_ray(mk_ray('0, MAXV, '0, '0, ALL1, '0));         // tiny negative dir
		send_ray(mk_ray('0, 32'd1, '0, '0, 32'd3, '0));       // truncation toward zero
		send_ray(mk_ray('0, -ONE, '0, '0, MINV, '0));
		send_ray(mk_ray(MAXV, '0, MINV, MINV, -ONE, MAXV));   // x/z don't matter
		send_ray(mk_ray(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
		send_ray(mk_ray(MINV, MINV, MINV, MINV, MINV, MINV));
		send_ray(mk_ray(ALL1, ALL1, ALL1, ALL1, ALL1, ALL1));
		ray_quiet();
		drain();

		// Random rounds, each with its own plane. Idling goes sender-light /
		// sink-heavy, then the reverse, then no idling at all.
		for (rnd = 0; rnd < CFG_ROUNDS; rnd++) begin
			case (rnd * 3 / CFG_ROUNDS)
				0: begin
					src_idle  = 29;
					sink_idle = 52;
				end
				1: begin
					src_idle  = 52;
					sink_idle = 29;
				end
				default: begin
					src_idle  = 0;
					sink_idle = 0;
				end
			endcase
			load_plane(random_plane(rnd));
			repeat (RAYS_PER_ROUND) send_ray(random_ray(plane_set));
			ray_quiet();
			drain();
		end

		// let any stray result show up past the end of the pipe
		repeat (60) @(negedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
